@@ rtl/fsa_pkg.sv @@
package fsa_pkg;

    localparam int SIZE_W     = 21;
    localparam int ID_W       = 32;
    localparam int OUT_ADDR_W = 20;
    localparam int MIN_SPLIT  = 1;

    localparam logic [1:0] REQ_ALLOC     = 2'd0;
    localparam logic [1:0] REQ_FREE_ID   = 2'd1;
    localparam logic [1:0] REQ_FREE_ADDR = 2'd2;
    localparam logic [1:0] REQ_NONE      = 2'd3;

    localparam logic [1:0] FIT_FIRST = 2'd0;
    localparam logic [1:0] FIT_BEST  = 2'd1;
    localparam logic [1:0] FIT_WORST = 2'd2;
    localparam logic [1:0] FIT_NONE  = 2'd3;

    localparam logic [2:0] ST_OK         = 3'd0;
    localparam logic [2:0] ST_ZERO_SIZE  = 3'd1;
    localparam logic [2:0] ST_NO_FIT     = 3'd2;
    localparam logic [2:0] ST_ID_UNKNOWN = 3'd3;
    localparam logic [2:0] ST_ADDR_UNKN  = 3'd4;
    localparam logic [2:0] ST_TABLE_FULL = 3'd5;

    localparam logic REG_FIT_MODE  = 1'b0;
    localparam logic REG_MEM_BYTES = 1'b1;

    typedef enum logic [3:0] {
        S_INIT,
        S_IDLE,
        S_SCAN,
        S_DECIDE,
        S_NB_NEXT,
        S_NB_PREV,
        S_NB_DONE,
        S_MERGE,
        S_SHIFT,
        S_WR_HI,
        S_WR_LO,
        S_DONE
    } t_state;

    typedef struct packed {
        logic [1:0]            req_type;
        logic [SIZE_W-1:0]     req_size;
        logic [ID_W-1:0]       req_id;
        logic [OUT_ADDR_W-1:0] req_address;
    } t_request;

    typedef struct packed {
        logic [2:0]            status;
        logic [ID_W-1:0]       granted_id;
        logic [OUT_ADDR_W-1:0] granted_address;
        logic [SIZE_W-1:0]     used_bytes;
    } t_result;

endpackage

@@ rtl/fsa_ram.sv @@
module fsa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

@@ rtl/fsa_ctrl.sv @@
module fsa_ctrl #(
    parameter int MAX_SEGMENTS = 64,
    parameter int START_W      = 20
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [1:0]                    i_fit_mode,
    input  logic [fsa_pkg::SIZE_W-1:0]    i_mem_bytes,
    input  logic                          i_reinit,
    input  logic                          i_req_valid,
    output logic                          o_req_ready,
    input  fsa_pkg::t_request             i_req,
    output logic                          o_res_valid,
    input  logic                          i_res_ready,
    output fsa_pkg::t_result              o_res,
    output logic                          o_ram_we,
    output logic [$clog2(MAX_SEGMENTS)-1:0] o_ram_waddr,
    output logic [START_W+53:0]           o_ram_wdata,
    output logic [$clog2(MAX_SEGMENTS)-1:0] o_ram_raddr,
    input  logic [START_W+53:0]           i_ram_rdata
);

    localparam int IW = $clog2(MAX_SEGMENTS);
    localparam int CW = $clog2(MAX_SEGMENTS + 1);
    localparam int SZ = fsa_pkg::SIZE_W;
    localparam int EW = START_W + 54;

    function automatic logic [EW-1:0] pack_entry(
        input logic [START_W-1:0] start,
        input logic [SZ-1:0]      size,
        input logic               free,
        input logic [31:0]        owner
    );
        pack_entry = {owner, free, size, start};
    endfunction

    fsa_pkg::t_state   r_state, n_state;
    fsa_pkg::t_state   r_after, n_after;
    fsa_pkg::t_request r_req, n_req;
    fsa_pkg::t_result  r_res, n_res;
    fsa_pkg::t_result  r_out, n_out;
    logic              r_out_valid, n_out_valid;
    logic [CW-1:0]     r_rd, n_rd;
    logic [CW-1:0]     r_left, n_left;
    logic              r_ev, n_ev;
    logic [IW-1:0]     r_ev_idx, n_ev_idx;
    logic              r_have, n_have;
    logic [IW-1:0]     r_pick, n_pick;
    logic [START_W-1:0] r_pstart, n_pstart;
    logic [SZ-1:0]     r_psize, n_psize;
    logic              r_nf, n_nf;
    logic [SZ-1:0]     r_nsize, n_nsize;
    logic              r_pf, n_pf;
    logic [START_W-1:0] r_prv_start, n_prv_start;
    logic [SZ-1:0]     r_prv_size, n_prv_size;
    logic              r_up, n_up;
    logic [1:0]        r_rm, n_rm;
    logic [CW-1:0]     r_count, n_count;
    logic [31:0]       r_next_id, n_next_id;
    logic [SZ-1:0]     r_used, n_used;

    logic [START_W-1:0] e_start;
    logic [SZ-1:0]      e_size;
    logic               e_free;
    logic [31:0]        e_owner;
    logic               fit_ok, fit_take, hit;
    logic               split;
    logic [SZ-1:0]      grant_size;
    logic [31:0]        id_inc;
    logic [CW-1:0]      rm_base;
    logic [CW-1:0]      rm_src;
    logic [1:0]         rm_cnt;
    logic [SZ-1:0]      merged;

    assign e_start = i_ram_rdata[START_W-1:0];
    assign e_size  = i_ram_rdata[START_W+SZ-1:START_W];
    assign e_free  = i_ram_rdata[START_W+SZ];
    assign e_owner = i_ram_rdata[EW-1:START_W+SZ+1];

    assign o_req_ready = (r_state == fsa_pkg::S_IDLE);
    assign o_res_valid = r_out_valid;
    assign o_res       = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= fsa_pkg::S_INIT;
            r_out_valid <= 1'b0;
            r_count     <= CW'(1);
            r_next_id   <= 32'd1;
            r_used      <= '0;
            r_ev        <= 1'b0;
            r_left      <= '0;
        end else begin
            r_state     <= i_reinit ? fsa_pkg::S_INIT : n_state;
            r_out_valid <= n_out_valid;
            r_count     <= n_count;
            r_next_id   <= n_next_id;
            r_used      <= n_used;
            r_ev        <= n_ev;
            r_left      <= n_left;
        end
    end

    always_ff @(posedge i_clk) begin
        r_after     <= n_after;
        r_req       <= n_req;
        r_res       <= n_res;
        r_out       <= n_out;
        r_rd        <= n_rd;
        r_ev_idx    <= n_ev_idx;
        r_have      <= n_have;
        r_pick      <= n_pick;
        r_pstart    <= n_pstart;
        r_psize     <= n_psize;
        r_nf        <= n_nf;
        r_nsize     <= n_nsize;
        r_pf        <= n_pf;
        r_prv_start <= n_prv_start;
        r_prv_size  <= n_prv_size;
        r_up        <= n_up;
        r_rm        <= n_rm;
    end

    always_comb begin
        n_state     = r_state;
        n_after     = r_after;
        n_req       = r_req;
        n_res       = r_res;
        n_out       = r_out;
        n_out_valid = r_out_valid && !i_res_ready;
        n_rd        = r_rd;
        n_left      = r_left;
        n_ev        = 1'b0;
        n_ev_idx    = r_ev_idx;
        n_have      = r_have;
        n_pick      = r_pick;
        n_pstart    = r_pstart;
        n_psize     = r_psize;
        n_nf        = r_nf;
        n_nsize     = r_nsize;
        n_pf        = r_pf;
        n_prv_start = r_prv_start;
        n_prv_size  = r_prv_size;
        n_up        = r_up;
        n_rm        = r_rm;
        n_count     = r_count;
        n_next_id   = r_next_id;
        n_used      = r_used;
        o_ram_we    = 1'b0;
        o_ram_waddr = '0;
        o_ram_wdata = '0;
        o_ram_raddr = r_rd[IW-1:0];

        fit_ok   = e_free && (e_size >= r_req.req_size) && (i_fit_mode != fsa_pkg::FIT_NONE);
        fit_take = fit_ok && (!r_have || (i_fit_mode == fsa_pkg::FIT_FIRST)
                   || ((i_fit_mode == fsa_pkg::FIT_BEST) && (e_size < r_psize))
                   || ((i_fit_mode == fsa_pkg::FIT_WORST) && (e_size > r_psize)));
        hit      = !e_free && (((r_req.req_type == fsa_pkg::REQ_FREE_ID)
                                && (e_owner == r_req.req_id))
                   || ((r_req.req_type == fsa_pkg::REQ_FREE_ADDR)
                       && (SZ'(e_start) == SZ'(r_req.req_address))));
        split      = ({1'b0, r_psize} > ({1'b0, r_req.req_size} + (SZ+1)'(fsa_pkg::MIN_SPLIT)));
        grant_size = split ? r_req.req_size : r_psize;
        id_inc     = r_next_id + 32'd1;
        rm_cnt     = {1'b0, r_pf} + {1'b0, r_nf};
        rm_base    = r_pf ? CW'(r_pick) : CW'(r_pick) + CW'(1);
        rm_src     = rm_base + CW'(rm_cnt);
        merged     = r_psize + (r_nf ? r_nsize : '0) + (r_pf ? r_prv_size : '0);

        case (r_state)
            fsa_pkg::S_INIT: begin
                o_ram_we    = 1'b1;
                o_ram_waddr = '0;
                o_ram_wdata = pack_entry('0, i_mem_bytes, 1'b1, '0);
                n_count     = CW'(1);
                n_next_id   = 32'd1;
                n_used      = '0;
                n_state     = fsa_pkg::S_IDLE;
            end
            fsa_pkg::S_IDLE: begin
                if (i_req_valid) begin
                    n_req  = i_req;
                    n_res  = '0;
                    n_rd   = '0;
                    n_left = r_count;
                    n_have = 1'b0;
                    if (i_req.req_type == fsa_pkg::REQ_NONE) begin
                        n_state = fsa_pkg::S_DONE;
                    end else if ((i_req.req_type == fsa_pkg::REQ_ALLOC)
                                 && (i_req.req_size == '0)) begin
                        n_res.status = fsa_pkg::ST_ZERO_SIZE;
                        n_state      = fsa_pkg::S_DONE;
                    end else begin
                        n_state = fsa_pkg::S_SCAN;
                    end
                end
            end
            fsa_pkg::S_SCAN: begin
                if (r_left != '0) begin
                    n_rd     = r_rd + CW'(1);
                    n_left   = r_left - CW'(1);
                    n_ev     = 1'b1;
                    n_ev_idx = r_rd[IW-1:0];
                end
                if (r_ev) begin
                    if (r_req.req_type == fsa_pkg::REQ_ALLOC) begin
                        if (fit_take) begin
                            n_have   = 1'b1;
                            n_pick   = r_ev_idx;
                            n_pstart = e_start;
                            n_psize  = e_size;
                            if (i_fit_mode == fsa_pkg::FIT_FIRST) begin
                                n_state = fsa_pkg::S_DECIDE;
                            end
                        end
                    end else if (hit) begin
                        n_pick   = r_ev_idx;
                        n_pstart = e_start;
                        n_psize  = e_size;
                        n_state  = fsa_pkg::S_NB_NEXT;
                    end
                end else if (r_left == '0) begin
                    // whole table seen
                    if (r_req.req_type == fsa_pkg::REQ_ALLOC) begin
                        n_state = fsa_pkg::S_DECIDE;
                    end else begin
                        n_res.status = (r_req.req_type == fsa_pkg::REQ_FREE_ID) ?
                                       fsa_pkg::ST_ID_UNKNOWN : fsa_pkg::ST_ADDR_UNKN;
                        n_state = fsa_pkg::S_DONE;
                    end
                end
            end
            fsa_pkg::S_DECIDE: begin
                n_ev   = 1'b0;
                n_left = '0;
                if (!r_have) begin
                    n_res.status = fsa_pkg::ST_NO_FIT;
                    n_state      = fsa_pkg::S_DONE;
                end else if (split && (r_count == CW'(MAX_SEGMENTS))) begin
                    n_res.status = fsa_pkg::ST_TABLE_FULL;
                    n_state      = fsa_pkg::S_DONE;
                end else if (split) begin
                    // open a hole above the pick, moving the top entry first
                    n_up    = 1'b1;
                    n_rm    = 2'd0;
                    n_rd    = r_count - CW'(1);
                    n_left  = r_count - CW'(1) - CW'(r_pick);
                    n_after = fsa_pkg::S_WR_HI;
                    n_state = fsa_pkg::S_SHIFT;
                end else begin
                    n_state = fsa_pkg::S_WR_LO;
                end
            end
            fsa_pkg::S_SHIFT: begin
                if (r_left != '0) begin
                    n_rd     = r_up ? r_rd - CW'(1) : r_rd + CW'(1);
                    n_left   = r_left - CW'(1);
                    n_ev     = 1'b1;
                    n_ev_idx = r_rd[IW-1:0];
                end
                if (r_ev) begin
                    o_ram_we    = 1'b1;
                    o_ram_waddr = r_up ? IW'(r_ev_idx + IW'(1)) : IW'(r_ev_idx - IW'(r_rm));
                    o_ram_wdata = i_ram_rdata;
                end else if (r_left == '0) begin
                    n_state = r_after;
                end
            end
            fsa_pkg::S_WR_HI: begin
                o_ram_we    = 1'b1;
                o_ram_waddr = IW'(r_pick + IW'(1));
                o_ram_wdata = pack_entry(START_W'({1'b0, r_pstart} + (START_W+1)'(r_req.req_size)),
                                         r_psize - r_req.req_size, 1'b1, '0);
                n_state     = fsa_pkg::S_WR_LO;
            end
            fsa_pkg::S_WR_LO: begin
                o_ram_we    = 1'b1;
                o_ram_waddr = r_pick;
                o_ram_wdata = pack_entry(r_pstart, grant_size, 1'b0, r_next_id);
                n_count     = r_count + CW'(split);
                n_used      = r_used + grant_size;
                n_res.status          = fsa_pkg::ST_OK;
                n_res.granted_id      = r_next_id;
                n_res.granted_address = fsa_pkg::OUT_ADDR_W'({{SZ{1'b0}}, r_pstart});
                n_next_id   = (id_inc == '0) ? 32'd1 : id_inc;
                n_state     = fsa_pkg::S_DONE;
            end
            fsa_pkg::S_NB_NEXT: begin
                n_ev        = 1'b0;
                n_left      = '0;
                o_ram_raddr = IW'(r_pick + IW'(1));
                n_state     = fsa_pkg::S_NB_PREV;
            end
            fsa_pkg::S_NB_PREV: begin
                n_nf        = ((CW'(r_pick) + CW'(1)) < r_count) && e_free;
                n_nsize     = e_size;
                o_ram_raddr = IW'(r_pick - IW'(1));
                n_state     = fsa_pkg::S_NB_DONE;
            end
            fsa_pkg::S_NB_DONE: begin
                n_pf        = (r_pick != '0) && e_free;
                n_prv_start = e_start;
                n_prv_size  = e_size;
                n_state     = fsa_pkg::S_MERGE;
            end
            fsa_pkg::S_MERGE: begin
                o_ram_we    = 1'b1;
                o_ram_waddr = r_pf ? IW'(r_pick - IW'(1)) : r_pick;
                o_ram_wdata = pack_entry(r_pf ? r_prv_start : r_pstart, merged, 1'b1, '0);
                n_used      = r_used - r_psize;
                n_res       = '0;
                // close the gap left by the absorbed neighbors
                n_up        = 1'b0;
                n_rm        = rm_cnt;
                n_rd        = rm_src;
                n_left      = (rm_cnt == 2'd0) ? '0 : r_count - rm_src;
                n_count     = r_count - CW'(rm_cnt);
                n_after     = fsa_pkg::S_DONE;
                n_state     = fsa_pkg::S_SHIFT;
            end
            fsa_pkg::S_DONE: begin
                if (!r_out_valid || i_res_ready) begin
                    n_out_valid          = 1'b1;
                    n_out                = r_res;
                    n_out.used_bytes     = r_used;
                    n_state              = fsa_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = fsa_pkg::S_INIT;
            end
        endcase
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count != '0) && (r_count <= CW'(MAX_SEGMENTS)))
        else $error("segment count out of range");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req_valid && o_req_ready && !i_reinit) |=> (r_state != fsa_pkg::S_IDLE))
        else $error("request accepted without processing");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != fsa_pkg::S_INIT) |-> (r_used <= i_mem_bytes))
        else $error("used bytes exceed managed memory");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_next_id != '0)
        else $error("next id reached zero");

endmodule

@@ rtl/fit_strategy_segment_allocator_unit.sv @@
// segment allocator over an address-ordered table of up to MAX_SEGMENTS entries
// requests enter on the s_axis channel: tuser carries the request type,
// tdata the size, id and start address; one result leaves on m_axis per request
// with the status in tuser and granted id, granted address and used bytes in tdata.
// o_s_axis_tready is high only while the sequencer is idle; one request is
// worked at a time through a single table ram, one entry per cycle.
// an allocate scans the live segments, first fit stopping the scan at the pick; a split
// then moves the entries above the pick up by one to open a hole; a free scans to the
// hit, reads both neighbors, writes the merged free segment and moves the entries above
// down over the absorbed ones, and a miss scans all live segments.
// zero size and type three requests go straight to the result without reading the table.
// the config port writes fit mode (index 0) or memory size (index 1); a size
// write reloads the table with one free segment.
// reset loads a single free segment in the same way.
// a stalled result stays in the output register; the next request may be
// accepted meanwhile and waits for the slot only when its result is ready.
module fit_strategy_segment_allocator_unit #(
    parameter int MAX_SEGMENTS = 64,
    parameter int ADDR_BITS    = 20
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [20:0] i_cfg_data,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    // req_type [1:0]
    input  logic [1:0]  i_s_axis_tuser,
    // req_size [20:0], req_id [52:21], req_address [72:53], zero fill above
    input  logic [79:0] i_s_axis_tdata,
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // status [2:0]
    output logic [2:0]  o_m_axis_tuser,
    // granted_id [31:0], granted_address [51:32], used_bytes [72:52], zero fill above
    output logic [79:0] o_m_axis_tdata
);

    localparam int START_W = (ADDR_BITS < 21) ? ADDR_BITS : 21;
    localparam int EW      = START_W + 54;
    localparam int IW      = $clog2(MAX_SEGMENTS);
    localparam logic [20:0] MEM_CAP   = (ADDR_BITS <= 20) ? 21'(64'd1 << ADDR_BITS)
                                                          : 21'h1FFFFF;
    localparam logic [20:0] MEM_RESET = (MEM_CAP < 21'd1048576) ? MEM_CAP : 21'd1048576;

    logic [1:0]        r_fit_mode;
    logic [20:0]       r_mem_bytes;
    logic              reinit;
    fsa_pkg::t_request req;
    fsa_pkg::t_result  res;
    logic              ram_we;
    logic [IW-1:0]     ram_waddr, ram_raddr;
    logic [EW-1:0]     ram_wdata, ram_rdata;

    assign reinit = i_cfg_we && (i_cfg_index == fsa_pkg::REG_MEM_BYTES);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fit_mode  <= fsa_pkg::FIT_FIRST;
            r_mem_bytes <= MEM_RESET;
        end else if (i_cfg_we) begin
            if (i_cfg_index == fsa_pkg::REG_FIT_MODE) begin
                r_fit_mode <= i_cfg_data[1:0];
            end else begin
                r_mem_bytes <= (i_cfg_data > MEM_CAP) ? MEM_CAP : i_cfg_data;
            end
        end
    end

    assign req.req_type    = i_s_axis_tuser;
    assign req.req_size    = i_s_axis_tdata[20:0];
    assign req.req_id      = i_s_axis_tdata[52:21];
    assign req.req_address = i_s_axis_tdata[72:53];

    assign o_m_axis_tuser = res.status;
    assign o_m_axis_tdata = {7'd0, res.used_bytes, res.granted_address, res.granted_id};

    fsa_ram #(
        .WIDTH (EW),
        .DEPTH (MAX_SEGMENTS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    fsa_ctrl #(
        .MAX_SEGMENTS (MAX_SEGMENTS),
        .START_W      (START_W)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fit_mode  (r_fit_mode),
        .i_mem_bytes (r_mem_bytes),
        .i_reinit    (reinit),
        .i_req_valid (i_s_axis_tvalid),
        .o_req_ready (o_s_axis_tready),
        .i_req       (req),
        .o_res_valid (o_m_axis_tvalid),
        .i_res_ready (i_m_axis_tready),
        .o_res       (res),
        .o_ram_we    (ram_we),
        .o_ram_waddr (ram_waddr),
        .o_ram_wdata (ram_wdata),
        .o_ram_raddr (ram_raddr),
        .i_ram_rdata (ram_rdata)
    );

endmodule

@@ test/fsa_result_checker.sv @@
`timescale 1ns / 100ps

module fsa_result_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [20:0] i_cfg_data,
    input  logic        i_s_axis_tvalid,
    input  logic        i_s_axis_tready,
    input  logic [1:0]  i_s_axis_tuser,
    input  logic [79:0] i_s_axis_tdata,
    input  logic        i_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    input  logic [2:0]  i_m_axis_tuser,
    input  logic [79:0] i_m_axis_tdata,
    output int          o_errors,
    output int          o_pending
);

    localparam int NSEG    = 64;
    localparam int MEM_CAP = 1048576;

    int          seg_start [NSEG];
    int          seg_size  [NSEG];
    bit          seg_free  [NSEG];
    logic [31:0] seg_owner [NSEG];
    int          seg_count;
    logic [31:0] next_id;
    int          used_total;
    logic [1:0]  fit_mode;
    int          mem_bytes;

    fsa_pkg::t_result expected_results [$];

    assign o_pending = expected_results.size();

    function automatic void table_reload();
        for (int k = 0; k < NSEG; k++) begin
            seg_start[k] = 0;
            seg_size[k]  = 0;
            seg_free[k]  = 0;
            seg_owner[k] = '0;
        end
        seg_size[0] = mem_bytes;
        seg_free[0] = 1;
        seg_count   = 1;
        next_id     = 32'd1;
        used_total  = 0;
    endfunction

    function automatic void drop_entry(int j);
        for (int k = j; k < seg_count - 1; k++) begin
            seg_start[k] = seg_start[k+1];
            seg_size[k]  = seg_size[k+1];
            seg_free[k]  = seg_free[k+1];
            seg_owner[k] = seg_owner[k+1];
        end
        seg_count--;
        seg_start[seg_count] = 0;
        seg_size[seg_count]  = 0;
        seg_free[seg_count]  = 0;
        seg_owner[seg_count] = '0;
    endfunction

    function automatic void open_entry(int j);
        for (int k = seg_count; k > j; k--) begin
            seg_start[k] = seg_start[k-1];
            seg_size[k]  = seg_size[k-1];
            seg_free[k]  = seg_free[k-1];
            seg_owner[k] = seg_owner[k-1];
        end
        seg_count++;
    endfunction

    function automatic int choose_segment(int size);
        int pick;
        pick = seg_count;
        for (int k = 0; k < seg_count; k++) begin
            if (!seg_free[k] || seg_size[k] < size) continue;
            if (fit_mode == fsa_pkg::FIT_FIRST) return k;
            if (pick == seg_count
                || (fit_mode == fsa_pkg::FIT_BEST && seg_size[k] < seg_size[pick])
                || (fit_mode == fsa_pkg::FIT_WORST && seg_size[k] > seg_size[pick]))
                pick = k;
        end
        return (fit_mode <= fsa_pkg::FIT_WORST) ? pick : seg_count;
    endfunction

    function automatic void release_segment(int i);
        used_total -= seg_size[i];
        seg_free[i]  = 1;
        seg_owner[i] = '0;
        while (i + 1 < seg_count && seg_free[i+1]) begin
            seg_size[i] += seg_size[i+1];
            drop_entry(i + 1);
        end
        if (i > 0 && seg_free[i-1]) begin
            seg_size[i-1] += seg_size[i];
            drop_entry(i);
        end
    endfunction

    function automatic fsa_pkg::t_result alloc_table_predict(fsa_pkg::t_request rq);
        fsa_pkg::t_result r;
        int      i;
        bit      found;
        r = '0;
        if (rq.req_type == fsa_pkg::REQ_ALLOC) begin
            if (rq.req_size == 0) begin
                r.status = fsa_pkg::ST_ZERO_SIZE;
            end else begin
                i = choose_segment(int'(rq.req_size));
                if (i >= seg_count) begin
                    r.status = fsa_pkg::ST_NO_FIT;
                end else if (seg_size[i] > int'(rq.req_size) + fsa_pkg::MIN_SPLIT
                             && seg_count >= NSEG) begin
                    r.status = fsa_pkg::ST_TABLE_FULL;
                end else begin
                    if (seg_size[i] > int'(rq.req_size) + fsa_pkg::MIN_SPLIT) begin
                        open_entry(i + 1);
                        seg_start[i+1] = seg_start[i] + int'(rq.req_size);
                        seg_size[i+1]  = seg_size[i] - int'(rq.req_size);
                        seg_free[i+1]  = 1;
                        seg_owner[i+1] = '0;
                        seg_size[i]    = int'(rq.req_size);
                    end
                    seg_free[i]       = 0;
                    seg_owner[i]      = next_id;
                    r.granted_id      = next_id;
                    r.granted_address = seg_start[i][19:0];
                    next_id++;
                    if (next_id == 0) next_id = 32'd1;
                    used_total += seg_size[i];
                end
            end
        end else if (rq.req_type == fsa_pkg::REQ_FREE_ID
                     || rq.req_type == fsa_pkg::REQ_FREE_ADDR) begin
            found = 0;
            for (i = 0; i < seg_count; i++) begin
                if (seg_free[i]) continue;
                if ((rq.req_type == fsa_pkg::REQ_FREE_ID && seg_owner[i] == rq.req_id)
                    || (rq.req_type == fsa_pkg::REQ_FREE_ADDR
                        && seg_start[i] == int'(rq.req_address))) begin
                    found = 1;
                    break;
                end
            end
            if (found) release_segment(i);
            else r.status = (rq.req_type == fsa_pkg::REQ_FREE_ID) ?
                            fsa_pkg::ST_ID_UNKNOWN : fsa_pkg::ST_ADDR_UNKN;
        end
        r.used_bytes = used_total[20:0];
        return r;
    endfunction

    // helpers for the stimulus: pick a live block, or a random value when none is
    function automatic logic [31:0] live_id();
        int n;
        n = 0;
        for (int k = 0; k < seg_count; k++) if (!seg_free[k]) n++;
        if (n == 0) return $urandom;
        n = $urandom_range(0, n - 1);
        for (int k = 0; k < seg_count; k++) begin
            if (!seg_free[k]) begin
                if (n == 0) return seg_owner[k];
                n--;
            end
        end
        return $urandom;
    endfunction

    function automatic logic [19:0] live_start();
        int n;
        n = 0;
        for (int k = 0; k < seg_count; k++) if (!seg_free[k]) n++;
        if (n == 0) return 20'($urandom);
        n = $urandom_range(0, n - 1);
        for (int k = 0; k < seg_count; k++) begin
            if (!seg_free[k]) begin
                if (n == 0) return seg_start[k][19:0];
                n--;
            end
        end
        return 20'($urandom);
    endfunction

    always @(posedge i_clk) begin
        fsa_pkg::t_request rq;
        fsa_pkg::t_result  act;
        fsa_pkg::t_result  exp_r;
        if (!i_rst_n) begin
            fit_mode  = fsa_pkg::FIT_FIRST;
            mem_bytes = MEM_CAP;
            table_reload();
            expected_results.delete();
            o_errors = 0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == fsa_pkg::REG_FIT_MODE) begin
                    fit_mode = i_cfg_data[1:0];
                end else begin
                    mem_bytes = (int'(i_cfg_data) > MEM_CAP) ? MEM_CAP : int'(i_cfg_data);
                    table_reload();
                end
            end
            if (i_s_axis_tvalid && i_s_axis_tready) begin
                rq.req_type    = i_s_axis_tuser;
                rq.req_size    = i_s_axis_tdata[20:0];
                rq.req_id      = i_s_axis_tdata[52:21];
                rq.req_address = i_s_axis_tdata[72:53];
                expected_results.push_back(alloc_table_predict(rq));
            end
            if (i_m_axis_tvalid && i_m_axis_tready) begin
                act.status          = i_m_axis_tuser;
                act.granted_id      = i_m_axis_tdata[31:0];
                act.granted_address = i_m_axis_tdata[51:32];
                act.used_bytes      = i_m_axis_tdata[72:52];
                if (expected_results.size() == 0) begin
                    $display("%0t: unexpected result st=%0d id=%0d addr=%0d used=%0d",
                             $time, act.status, act.granted_id, act.granted_address,
                             act.used_bytes);
                    o_errors++;
                end else begin
                    exp_r = expected_results.pop_front();
                    if (act !== exp_r) begin
                        $display("%0t: mismatch exp st=%0d id=%0d addr=%0d used=%0d",
                                 $time, exp_r.status, exp_r.granted_id,
                                 exp_r.granted_address, exp_r.used_bytes);
                        $display("%0t:          act st=%0d id=%0d addr=%0d used=%0d",
                                 $time, act.status, act.granted_id,
                                 act.granted_address, act.used_bytes);
                        o_errors++;
                    end
                end
            end
        end
    end

endmodule

@@ test/tb_fit_strategy_segment_allocator_unit.sv @@
`timescale 1ns / 100ps

module tb_fit_strategy_segment_allocator_unit;

    localparam int CYCLE_LIMIT = 1000000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic        i_cfg_index = 1'b0;
    logic [20:0] i_cfg_data = '0;
    logic        i_s_axis_tvalid = 1'b0;
    logic        o_s_axis_tready;
    logic [1:0]  i_s_axis_tuser = '0;
    logic [79:0] i_s_axis_tdata = '0;
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready = 1'b1;
    logic [2:0]  o_m_axis_tuser;
    logic [79:0] o_m_axis_tdata;

    int errors;
    int pending;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int hold_asked = 0;
    int hold_seen = 0;
    int hold_left = 0;
    int cycles = 0;
    int mem_now = 1048576;

    always #4 i_clk = ~i_clk;

    fit_strategy_segment_allocator_unit u_top (.*);

    fsa_result_checker u_chk (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .i_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .i_m_axis_tuser  (o_m_axis_tuser),
        .i_m_axis_tdata  (o_m_axis_tdata),
        .o_errors        (errors),
        .o_pending       (pending)
    );

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // result side: random stalls, plus a long hold-off on request
    always @(negedge i_clk) begin
        if (hold_seen != hold_asked) begin
            hold_seen = hold_asked;
            hold_left = 400;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_m_axis_tready = 1'b0;
        end else begin
            i_m_axis_tready = ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    task automatic send_request(logic [1:0] kind, logic [20:0] size,
                                logic [31:0] id, logic [19:0] addr);
        while ($urandom_range(0, 99) < send_idle_pct) @(negedge i_clk);
        i_s_axis_tvalid = 1'b1;
        i_s_axis_tuser  = kind;
        i_s_axis_tdata  = {7'd0, addr, id, size};
        do @(posedge i_clk); while (!o_s_axis_tready);
        @(negedge i_clk);
        i_s_axis_tvalid = 1'b0;
    endtask

    task automatic drain();
        while (pending != 0) @(negedge i_clk);
        repeat (200) @(negedge i_clk);
    endtask

    task automatic write_reg(logic idx, logic [20:0] val);
        drain();
        i_cfg_we    = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = val;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        if (idx == fsa_pkg::REG_MEM_BYTES) mem_now = (val > 21'd1048576) ? 1048576 : val;
    endtask

    task automatic random_request();
        int r;
        int s;
        r = $urandom_range(0, 99);
        if (r < 55) begin
            s = $urandom_range(0, 99);
            if (s < 70)
                send_request(fsa_pkg::REQ_ALLOC, 21'($urandom_range(1, mem_now / 16 + 1)),
                             $urandom, 20'($urandom));
            else if (s < 90)
                send_request(fsa_pkg::REQ_ALLOC, 21'($urandom_range(1, 4)),
                             $urandom, 20'($urandom));
            else if (s < 98)
                send_request(fsa_pkg::REQ_ALLOC, 21'($urandom_range(0, 1048576)),
                             $urandom, 20'($urandom));
            else
                send_request(fsa_pkg::REQ_ALLOC, 21'd0, $urandom, 20'($urandom));
        end else if (r < 75) begin
            if ($urandom_range(0, 9) < 8)
                send_request(fsa_pkg::REQ_FREE_ID, 21'($urandom), u_chk.live_id(),
                             20'($urandom));
            else
                send_request(fsa_pkg::REQ_FREE_ID, 21'($urandom), $urandom, 20'($urandom));
        end else if (r < 93) begin
            if ($urandom_range(0, 9) < 8)
                send_request(fsa_pkg::REQ_FREE_ADDR, 21'($urandom), $urandom,
                             u_chk.live_start());
            else
                send_request(fsa_pkg::REQ_FREE_ADDR, 21'($urandom), $urandom, 20'($urandom));
        end else begin
            send_request(fsa_pkg::REQ_NONE, 21'($urandom), $urandom, 20'($urandom));
        end
    endtask

    initial begin
        repeat (2) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // directed: whole memory, zero size, unknown targets, ignored type
        send_request(fsa_pkg::REQ_ALLOC, 21'd0, '0, '0);
        send_request(fsa_pkg::REQ_ALLOC, 21'd1048576, '0, '0);
        send_request(fsa_pkg::REQ_ALLOC, 21'd1, '0, '0);
        send_request(fsa_pkg::REQ_FREE_ADDR, '0, '0, 20'd0);
        send_request(fsa_pkg::REQ_FREE_ID, '0, 32'd1, '0);
        send_request(fsa_pkg::REQ_FREE_ID, '0, 32'd0, '0);
        send_request(fsa_pkg::REQ_FREE_ID, '0, 32'hFFFFFFFF, '0);
        send_request(fsa_pkg::REQ_FREE_ADDR, '0, '0, 20'hFFFFF);
        send_request(fsa_pkg::REQ_NONE, 21'h1FFFFF, 32'hFFFFFFFF, 20'hFFFFF);
        // small memory: exact fit, remainder of one byte, merging both sides
        write_reg(fsa_pkg::REG_MEM_BYTES, 21'd300);
        send_request(fsa_pkg::REQ_ALLOC, 21'd100, '0, '0);
        send_request(fsa_pkg::REQ_ALLOC, 21'd50, '0, '0);
        send_request(fsa_pkg::REQ_ALLOC, 21'd100, '0, '0);
        send_request(fsa_pkg::REQ_FREE_ID, '0, 32'd2, '0);
        send_request(fsa_pkg::REQ_ALLOC, 21'd49, '0, '0);
        send_request(fsa_pkg::REQ_ALLOC, 21'd301, '0, '0);
        send_request(fsa_pkg::REQ_FREE_ADDR, '0, '0, 20'd100);
        send_request(fsa_pkg::REQ_FREE_ADDR, '0, '0, 20'd0);
        send_request(fsa_pkg::REQ_FREE_ID, '0, 32'd3, '0);
        write_reg(fsa_pkg::REG_FIT_MODE, 21'(fsa_pkg::FIT_BEST));
        send_request(fsa_pkg::REQ_ALLOC, 21'd50, '0, '0);
        write_reg(fsa_pkg::REG_FIT_MODE, 21'(fsa_pkg::FIT_NONE));
        send_request(fsa_pkg::REQ_ALLOC, 21'd5, '0, '0);
        write_reg(fsa_pkg::REG_MEM_BYTES, 21'd0);
        send_request(fsa_pkg::REQ_ALLOC, 21'd1, '0, '0);
        write_reg(fsa_pkg::REG_MEM_BYTES, 21'h1FFFFF);
        send_request(fsa_pkg::REQ_ALLOC, 21'd1048576, '0, '0);
        write_reg(fsa_pkg::REG_MEM_BYTES, 21'd1);
        send_request(fsa_pkg::REQ_ALLOC, 21'd1, '0, '0);

        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin
                    send_idle_pct = 0;  recv_stall_pct = 0;
                    write_reg(fsa_pkg::REG_FIT_MODE, 21'(fsa_pkg::FIT_FIRST));
                    write_reg(fsa_pkg::REG_MEM_BYTES, 21'd1048576);
                end
                1: begin
                    send_idle_pct = 62; recv_stall_pct = 0;
                    write_reg(fsa_pkg::REG_FIT_MODE, 21'(fsa_pkg::FIT_BEST));
                    write_reg(fsa_pkg::REG_MEM_BYTES, 21'd4096);
                end
                2: begin
                    send_idle_pct = 0;  recv_stall_pct = 62;
                    write_reg(fsa_pkg::REG_FIT_MODE, 21'(fsa_pkg::FIT_WORST));
                    write_reg(fsa_pkg::REG_MEM_BYTES, 21'd200);
                end
                default: begin
                    send_idle_pct = 27; recv_stall_pct = 27;
                    write_reg(fsa_pkg::REG_FIT_MODE, 21'(fsa_pkg::FIT_FIRST));
                    write_reg(fsa_pkg::REG_MEM_BYTES, 21'd65536);
                end
            endcase
            for (int n = 0; n < 132; n++) begin
                if (ph == 2 && n == 40) hold_asked++;
                if (ph == 1 && n == 60) drain();
                if (ph == 3 && n == 80)
                    write_reg(fsa_pkg::REG_FIT_MODE, 21'(fsa_pkg::FIT_NONE));
                if (ph == 3 && n == 90)
                    write_reg(fsa_pkg::REG_FIT_MODE, 21'(fsa_pkg::FIT_WORST));
                random_request();
            end
        end

        drain();
        if (errors == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
